// ----- rtl/core/mbss_pkg.sv -----
package mbss_pkg;

    localparam int SEGMENT_BITS_DEF = 16;
    localparam int SEG_FIELD_W      = 16;
    localparam int BYTE_W           = 8;
    localparam int HDR_BYTES        = 8;
    localparam int HDR_W            = HDR_BYTES * BYTE_W;
    localparam int FIFO_DEPTH       = 16;
    localparam int TDATA_W          = 24;
    localparam int TUSER_W          = 3;

    localparam logic [31:0] FOURCC_SIDX = 32'h73696478;
    localparam logic [31:0] FOURCC_MDAT = 32'h6d646174;
    localparam logic [31:0] MIN_BOX_SIZE = 32'd8;

    typedef struct packed {
        logic                   is_hdr;
        logic [HDR_W-1:0]       hdr;
        logic [SEG_FIELD_W-1:0] seg;
        logic                   sstart;
        logic                   bad;
    } entry_t;

    typedef struct packed {
        logic   push;
        entry_t entry;
    } push_t;

    typedef struct packed {
        logic   empty;
        entry_t entry;
    } head_t;

endpackage

// ----- rtl/core/mbss_front.sv -----
module mbss_front #(
    parameter int SEGMENT_BITS = mbss_pkg::SEGMENT_BITS_DEF
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [mbss_pkg::BYTE_W-1:0]    s_tdata,
    input  logic                           full,
    output mbss_pkg::push_t                wr
);

    localparam int CNT_W = (SEGMENT_BITS < mbss_pkg::SEG_FIELD_W) ?
                           SEGMENT_BITS : mbss_pkg::SEG_FIELD_W;
    localparam logic [CNT_W-1:0] SEG_MAX = {CNT_W{1'b1}};

    logic [mbss_pkg::HDR_W-1:0] hdr_reg, hdr_next, hdr_new;
    logic [2:0]                 cnt_reg, cnt_next;
    logic [31:0]                pl_reg, pl_next;
    logic [CNT_W-1:0]           seg_reg, seg_next;
    logic                       mdat_reg, mdat_next;
    logic                       started_reg, started_next;

    logic        accept;
    logic [31:0] box_size;
    logic [31:0] box_type;
    logic        bad;
    logic        split;
    logic        in_payload;

    assign s_tready   = !full;
    assign accept     = s_tvalid && !full;
    assign in_payload = (pl_reg != 32'd0);
    assign hdr_new    = {hdr_reg[mbss_pkg::HDR_W-mbss_pkg::BYTE_W-1:0], s_tdata};
    assign box_size   = hdr_new[63:32];
    assign box_type   = hdr_new[31:0];
    assign bad        = box_size < mbss_pkg::MIN_BOX_SIZE;
    assign split      = (box_type == mbss_pkg::FOURCC_SIDX) &&
                        ((seg_reg == '0) || mdat_reg) && (seg_reg != SEG_MAX);

    always_comb begin
        hdr_next     = hdr_reg;
        cnt_next     = cnt_reg;
        pl_next      = pl_reg;
        seg_next     = seg_reg;
        mdat_next    = mdat_reg;
        started_next = started_reg;
        wr.push      = 1'b0;
        wr.entry     = '0;
        if (accept) begin
            if (in_payload) begin
                pl_next            = pl_reg - 32'd1;
                wr.push            = 1'b1;
                wr.entry.is_hdr    = 1'b0;
                wr.entry.hdr       = {{(mbss_pkg::HDR_W-mbss_pkg::BYTE_W){1'b0}}, s_tdata};
                wr.entry.seg       = mbss_pkg::SEG_FIELD_W'(seg_reg);
            end else begin
                hdr_next = hdr_new;
                cnt_next = cnt_reg + 3'd1;
                if (cnt_reg == 3'd7) begin
                    if (split) begin
                        seg_next  = seg_reg + 1'b1;
                        mdat_next = 1'b0;
                    end else if (box_type == mbss_pkg::FOURCC_MDAT) begin
                        mdat_next = 1'b1;
                    end
                    started_next    = 1'b1;
                    pl_next         = bad ? 32'd0 : box_size - mbss_pkg::MIN_BOX_SIZE;
                    wr.push         = 1'b1;
                    wr.entry.is_hdr = 1'b1;
                    wr.entry.hdr    = hdr_new;
                    wr.entry.seg    = mbss_pkg::SEG_FIELD_W'(seg_next);
                    wr.entry.sstart = split || !started_reg;
                    wr.entry.bad    = bad;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        hdr_reg <= hdr_next;
        if (!aresetn) begin
            cnt_reg     <= '0;
            pl_reg      <= '0;
            seg_reg     <= '0;
            mdat_reg    <= 1'b0;
            started_reg <= 1'b0;
        end else begin
            cnt_reg     <= cnt_next;
            pl_reg      <= pl_next;
            seg_reg     <= seg_next;
            mdat_reg    <= mdat_next;
            started_reg <= started_next;
        end
    end

`ifndef SYNTHESIS
    a_payload_holds_count: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && in_payload) |=> (cnt_reg == $past(cnt_reg)))
        else $error("header count moved during payload");
    a_header_pushes: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && !in_payload && cnt_reg == 3'd7) |=> (cnt_reg == 3'd0))
        else $error("header count not cleared after header");
    a_seg_saturates: assert property (@(posedge aclk) disable iff (!aresetn)
        ($past(seg_reg) == SEG_MAX) |-> (seg_reg == SEG_MAX))
        else $error("segment count wrapped");
`endif

endmodule

// ----- rtl/core/mbss_fifo.sv -----
module mbss_fifo (
    input  logic            aclk,
    input  logic            aresetn,
    input  mbss_pkg::push_t wr,
    output logic            full,
    input  logic            pop,
    output mbss_pkg::head_t rd
);

    localparam int DEPTH = mbss_pkg::FIFO_DEPTH;
    localparam int AW    = $clog2(DEPTH);

    mbss_pkg::entry_t mem [DEPTH];
    logic [AW-1:0]    wp_reg, rp_reg;
    logic [AW:0]      cnt_reg;
    logic             do_push, do_pop;

    assign full     = (cnt_reg == (AW+1)'(DEPTH));
    assign rd.empty = (cnt_reg == '0);
    assign rd.entry = mem[rp_reg];
    assign do_push  = wr.push && !full;
    assign do_pop   = pop && !rd.empty;

    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem[wp_reg] <= wr.entry;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wp_reg  <= '0;
            rp_reg  <= '0;
            cnt_reg <= '0;
        end else begin
            if (do_push) begin
                wp_reg <= wp_reg + 1'b1;
            end
            if (do_pop) begin
                rp_reg <= rp_reg + 1'b1;
            end
            cnt_reg <= cnt_reg + (AW+1)'(do_push) - (AW+1)'(do_pop);
        end
    end

`ifndef SYNTHESIS
    a_cnt_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg <= (AW+1)'(DEPTH))
        else $error("fifo overflow");
    a_no_push_full: assert property (@(posedge aclk) disable iff (!aresetn)
        !(wr.push && full))
        else $error("push while full");
`endif

endmodule

// ----- rtl/core/mbss_back.sv -----
module mbss_back (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  mbss_pkg::head_t                  rd,
    output logic                             pop,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [mbss_pkg::TDATA_W-1:0]     m_tdata,
    output logic [mbss_pkg::TUSER_W-1:0]     m_tuser,
    output logic                             m_tlast
);

    logic [mbss_pkg::HDR_W-1:0]       sh_reg, sh_next;
    logic [2:0]                       left_reg, left_next;
    logic [mbss_pkg::SEG_FIELD_W-1:0] seg_reg, seg_next;
    logic                             bad_reg, bad_next;
    logic                             vld_reg, vld_next;
    logic [mbss_pkg::TDATA_W-1:0]     data_reg, data_next;
    logic [mbss_pkg::TUSER_W-1:0]     user_reg, user_next;
    logic                             last_reg, last_next;
    logic                             load;

    assign load     = !vld_reg || m_tready;
    assign pop      = load && (left_reg == 3'd0) && !rd.empty;
    assign m_tvalid = vld_reg;
    assign m_tdata  = data_reg;
    assign m_tuser  = user_reg;
    assign m_tlast  = last_reg;

    always_comb begin
        sh_next   = sh_reg;
        left_next = left_reg;
        seg_next  = seg_reg;
        bad_next  = bad_reg;
        vld_next  = vld_reg;
        data_next = data_reg;
        user_next = user_reg;
        last_next = last_reg;
        if (load) begin
            vld_next = 1'b0;
            if (left_reg != 3'd0) begin
                vld_next  = 1'b1;
                data_next = {seg_reg, sh_reg[63:56]};
                user_next = {bad_reg, 1'b0, 1'b0};
                last_next = (left_reg == 3'd1);
                sh_next   = sh_reg << mbss_pkg::BYTE_W;
                left_next = left_reg - 3'd1;
            end else if (!rd.empty) begin
                vld_next = 1'b1;
                if (rd.entry.is_hdr) begin
                    data_next = {rd.entry.seg, rd.entry.hdr[63:56]};
                    user_next = {rd.entry.bad, 1'b1, rd.entry.sstart};
                    last_next = 1'b0;
                    sh_next   = rd.entry.hdr << mbss_pkg::BYTE_W;
                    left_next = 3'd7;
                    seg_next  = rd.entry.seg;
                    bad_next  = rd.entry.bad;
                end else begin
                    data_next = {rd.entry.seg, rd.entry.hdr[7:0]};
                    user_next = '0;
                    last_next = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        sh_reg   <= sh_next;
        seg_reg  <= seg_next;
        bad_reg  <= bad_next;
        data_reg <= data_next;
        user_reg <= user_next;
        last_reg <= last_next;
        if (!aresetn) begin
            left_reg <= '0;
            vld_reg  <= 1'b0;
        end else begin
            left_reg <= left_next;
            vld_reg  <= vld_next;
        end
    end

`ifndef SYNTHESIS
    a_burst_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        (left_reg != 3'd0) |-> vld_reg)
        else $error("header burst without valid word");
    a_pop_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        pop |-> (left_reg == 3'd0))
        else $error("pop during header burst");
    a_burst_step: assert property (@(posedge aclk) disable iff (!aresetn)
        (left_reg != 3'd0 && m_tready) |=> (left_reg == $past(left_reg) - 3'd1))
        else $error("header burst skipped a byte");
`endif

endmodule

// ----- rtl/core/mp4_box_segment_splitter_top.sv -----
// Fragmented MP4 box splitter for segmenting.
// Input stream (s_): one stream byte per word in s_tdata.
// Output stream (m_): one word per passed byte. Each box header is gathered
// and then sent as a burst of eight words, first with m_tuser box start set;
// each payload byte is sent as one word with m_tlast set.
// A sidx opens a new segment when the current one is the initial segment or
// an mdat arrived since the last split; the segment counter saturates.
// Boxes declaring a size below 8 get bad_size on their header words and no
// payload.
// Throughput: one byte per cycle sustained while m_tready stays high; header bursts
// of eight words are absorbed by the sixteen-entry queue between the parser and
// the serializer, since seven header bytes produce no output.
// An accepted byte is written to the queue and then loaded into the output register
// to form its word (the eighth header byte forms the first header word).
// Reset clears the parser, queue and output register; the first box starts
// segment 0, or segment 1 if it is a sidx. When m_tready is low, output words
// hold and the queue fills, then s_tready drops.
module mp4_box_segment_splitter_top #(
    parameter int SEGMENT_BITS = mbss_pkg::SEGMENT_BITS_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [mbss_pkg::BYTE_W-1:0]   s_tdata,   // data_byte
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [mbss_pkg::TDATA_W-1:0]  m_tdata,   // out_byte, segment_index
    output logic [mbss_pkg::TUSER_W-1:0]  m_tuser,   // segment_start, box_start, bad_size
    output logic                          m_tlast
);

    mbss_pkg::push_t wr;
    mbss_pkg::head_t rd;
    logic            full;
    logic            pop;

    mbss_front #(
        .SEGMENT_BITS(SEGMENT_BITS)
    ) u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .full     (full),
        .wr       (wr)
    );

    mbss_fifo u_fifo (
        .aclk    (aclk),
        .aresetn (aresetn),
        .wr      (wr),
        .full    (full),
        .pop     (pop),
        .rd      (rd)
    );

    mbss_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .rd       (rd),
        .pop      (pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

endmodule

// ----- bench/tb_mp4_box_segment_splitter_top.sv -----
module tb_mp4_box_segment_splitter_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int SEG_BITS = 4;

    typedef struct packed {
        logic [7:0]  out_byte;
        logic [15:0] seg;
        logic        sstart;
        logic        bstart;
        logic        bad;
        logic        lst;
    } word_t;

    typedef struct packed {
        logic [7:0]  data;
        bit          typed;
        logic [15:0] seg;
        bit          sstart;
        bit          bad;
    } stim_row_t;

    logic                           aclk = 1'b0;
    logic                           aresetn = 1'b0;
    logic                           s_tvalid = 1'b0;
    logic                           s_tready;
    logic [mbss_pkg::BYTE_W-1:0]    s_tdata = '0;
    logic                           m_tvalid;
    logic                           m_tready = 1'b0;
    logic [mbss_pkg::TDATA_W-1:0]   m_tdata;   // out_byte, segment_index
    logic [mbss_pkg::TUSER_W-1:0]   m_tuser;   // segment_start, box_start, bad_size
    logic                           m_tlast;

    word_t       word_q[$];
    int unsigned err_cnt = 0;
    int unsigned sent = 0;
    int unsigned tx_idle = 0;
    int unsigned rx_stall = 0;

    logic [63:0] hdr_shift = '0;
    logic [3:0]  hdr_cnt = '0;
    logic [31:0] pay_left = '0;
    logic [15:0] seg_cnt = '0;
    bit          mdat_flag = 1'b0;
    bit          started = 1'b0;

    stim_row_t dir_tab[25] = '{
        '{8'h00, 1'b0, 16'd0, 1'b0, 1'b0}, '{8'h00, 1'b0, 16'd0, 1'b0, 1'b0},
        '{8'h00, 1'b0, 16'd0, 1'b0, 1'b0}, '{8'h00, 1'b0, 16'd0, 1'b0, 1'b0},
        '{8'h73, 1'b0, 16'd0, 1'b0, 1'b0}, '{8'h69, 1'b0, 16'd0, 1'b0, 1'b0},
        '{8'h64, 1'b0, 16'd0, 1'b0, 1'b0}, '{8'h78, 1'b1, 16'd1, 1'b1, 1'b1},
        '{8'h00, 1'b0, 16'd0, 1'b0, 1'b0}, '{8'h00, 1'b0, 16'd0, 1'b0, 1'b0},
        '{8'h00, 1'b0, 16'd0, 1'b0, 1'b0}, '{8'h09, 1'b0, 16'd0, 1'b0, 1'b0},
        '{8'h6d, 1'b0, 16'd0, 1'b0, 1'b0}, '{8'h64, 1'b0, 16'd0, 1'b0, 1'b0},
        '{8'h61, 1'b0, 16'd0, 1'b0, 1'b0}, '{8'h74, 1'b1, 16'd1, 1'b0, 1'b0},
        '{8'hff, 1'b0, 16'd0, 1'b0, 1'b0},
        '{8'h00, 1'b0, 16'd0, 1'b0, 1'b0}, '{8'h00, 1'b0, 16'd0, 1'b0, 1'b0},
        '{8'h00, 1'b0, 16'd0, 1'b0, 1'b0}, '{8'h01, 1'b0, 16'd0, 1'b0, 1'b0},
        '{8'h73, 1'b0, 16'd0, 1'b0, 1'b0}, '{8'h69, 1'b0, 16'd0, 1'b0, 1'b0},
        '{8'h64, 1'b0, 16'd0, 1'b0, 1'b0}, '{8'h78, 1'b1, 16'd2, 1'b1, 1'b1}
    };

    mp4_box_segment_splitter_top #(
        .SEGMENT_BITS(SEG_BITS)
    ) dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    initial begin
        forever #1 aclk = ~aclk;
    end

    initial begin
        #200000;
        $display("Regression FAIL");
        $finish;
    end

    function automatic void split_predict(input logic [7:0] b, input stim_row_t row);
        logic [31:0] bsize;
        logic [31:0] btype;
        logic [15:0] seg_top;
        bit          bad;
        bit          ss;
        word_t       w;
        seg_top = (SEG_BITS >= 16) ? 16'hffff : 16'((1 << SEG_BITS) - 1);
        if (pay_left != 0) begin
            pay_left = pay_left - 1;
            w = '{b, seg_cnt, 1'b0, 1'b0, 1'b0, 1'b1};
            word_q.push_back(w);
            return;
        end
        hdr_shift = {hdr_shift[55:0], b};
        hdr_cnt = hdr_cnt + 1'b1;
        if (hdr_cnt < mbss_pkg::HDR_BYTES)
            return;
        hdr_cnt = '0;
        bsize = hdr_shift[63:32];
        btype = hdr_shift[31:0];
        bad = bsize < mbss_pkg::MIN_BOX_SIZE;
        ss = !started;
        if (btype == mbss_pkg::FOURCC_SIDX) begin
            if ((seg_cnt == 0 || mdat_flag) && seg_cnt < seg_top) begin
                seg_cnt = seg_cnt + 1'b1;
                mdat_flag = 1'b0;
                ss = 1'b1;
            end
        end else if (btype == mbss_pkg::FOURCC_MDAT) begin
            mdat_flag = 1'b1;
        end
        started = 1'b1;
        pay_left = bad ? 32'd0 : bsize - mbss_pkg::MIN_BOX_SIZE;
        for (int k = 0; k < mbss_pkg::HDR_BYTES; k++) begin
            w.out_byte = hdr_shift[8*(mbss_pkg::HDR_BYTES-1-k) +: 8];
            w.seg = row.typed ? row.seg : seg_cnt;
            w.sstart = (row.typed ? row.sstart : ss) && k == 0;
            w.bstart = k == 0;
            w.bad = row.typed ? row.bad : bad;
            w.lst = k == mbss_pkg::HDR_BYTES - 1;
            word_q.push_back(w);
        end
        hdr_shift = '0;
    endfunction

    task automatic send_byte(input logic [7:0] b, input stim_row_t row);
        case ((sent / 70) % 4)
            0: begin tx_idle = 0;  rx_stall = 0;  end
            1: begin tx_idle = 63; rx_stall = 0;  end
            2: begin tx_idle = 0;  rx_stall = 63; end
            default: begin tx_idle = 18; rx_stall = 18; end
        endcase
        while ($urandom_range(99) < tx_idle) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= b;
        @(posedge aclk);
        while (!s_tready)
            @(posedge aclk);
        split_predict(b, row);
        sent++;
        @(negedge aclk);
    endtask

    task automatic send_box();
        stim_row_t   plain;
        logic [31:0] bsize;
        logic [31:0] btype;
        int unsigned r;
        plain = '0;
        r = $urandom_range(99);
        if (r < 15)
            bsize = $urandom_range(7, 0);
        else if (r < 90)
            bsize = 8 + $urandom_range(6, 0);
        else
            bsize = 15 + $urandom_range(25, 0);
        r = $urandom_range(99);
        if (r < 40)
            btype = mbss_pkg::FOURCC_SIDX;
        else if (r < 80)
            btype = mbss_pkg::FOURCC_MDAT;
        else if (r < 90)
            btype = ($urandom_range(1) ? mbss_pkg::FOURCC_SIDX : mbss_pkg::FOURCC_MDAT)
                    ^ (32'h1 << $urandom_range(31));
        else
            btype = $urandom;
        for (int k = 3; k >= 0; k--)
            send_byte(bsize[8*k +: 8], plain);
        for (int k = 3; k >= 0; k--)
            send_byte(btype[8*k +: 8], plain);
        if (bsize >= mbss_pkg::MIN_BOX_SIZE)
            for (int k = 0; k < bsize - mbss_pkg::MIN_BOX_SIZE; k++)
                send_byte(8'($urandom), plain);
    endtask

    always @(negedge aclk) begin
        m_tready <= ($urandom_range(99) >= rx_stall);
    end

    always @(posedge aclk) begin
        word_t w;
        if (aresetn && m_tvalid && m_tready) begin
            if (word_q.size() == 0) begin
                $error("unexpected word: tdata %h tuser %b tlast %b",
                       m_tdata, m_tuser, m_tlast);
                err_cnt++;
            end else begin
                w = word_q.pop_front();
                if (m_tdata[7:0] !== w.out_byte) begin
                    $error("out_byte expected %h got %h", w.out_byte, m_tdata[7:0]);
                    err_cnt++;
                end
                if (m_tdata[23:8] !== w.seg) begin
                    $error("segment_index expected %0d got %0d", w.seg, m_tdata[23:8]);
                    err_cnt++;
                end
                if (m_tuser[0] !== w.sstart) begin
                    $error("segment_start expected %b got %b", w.sstart, m_tuser[0]);
                    err_cnt++;
                end
                if (m_tuser[1] !== w.bstart) begin
                    $error("box_start expected %b got %b", w.bstart, m_tuser[1]);
                    err_cnt++;
                end
                if (m_tuser[2] !== w.bad) begin
                    $error("bad_size expected %b got %b", w.bad, m_tuser[2]);
                    err_cnt++;
                end
                if (m_tlast !== w.lst) begin
                    $error("last expected %b got %b", w.lst, m_tlast);
                    err_cnt++;
                end
            end
        end
    end

    initial begin
        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        foreach (dir_tab[i])
            send_byte(dir_tab[i].data, dir_tab[i]);
        while (sent < 280)
            send_box();
        s_tvalid <= 1'b0;
        rx_stall = 0;
        while (word_q.size() != 0)
            @(posedge aclk);
        repeat (8) @(posedge aclk);
        if (err_cnt == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
